>>> rtl/core/rope_pkg.sv
// rope_pkg: shared types and constants for the rotate-half fp16 datapath
// no dependencies
package rope_pkg;

    localparam int unsigned ProdW  = 22;   // 11 x 11 significand product
    localparam int unsigned AccW   = 64;   // aligned sum width (room for 22 + 40 + carry)
    localparam int unsigned AlignCap = 40;
    localparam logic [15:0] QNan   = 16'h7E00;
    localparam logic [15:0] PosInf = 16'h7C00;

    typedef enum logic [1:0] {
        CLS_FIN = 2'd0,
        CLS_INF = 2'd1,
        CLS_NAN = 2'd2
    } t_cls;

    // one product term: value = mag * 2^ex
    typedef struct packed {
        t_cls              cls;
        logic              sign;
        logic [ProdW-1:0]  mag;
        logic signed [7:0] ex;
    } t_term;

    // aligned sum ready for rounding, or a fixed special answer
    typedef struct packed {
        logic              special;
        logic [15:0]       spec_val;
        logic              sign;
        logic [AccW-1:0]   mag;
        logic signed [7:0] ex;
    } t_sum;

endpackage

>>> rtl/core/rope_mul.sv
// rope_mul: one fp16 x fp16 exact product term, registered
// depends on rope_pkg
module rope_mul
    import rope_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    input  logic        i_neg,
    output t_term       o_term
);

    logic [4:0]  w_fa, w_fb;
    logic [10:0] w_ma, w_mb;
    logic        w_nana, w_nanb, w_infa, w_infb, w_zera, w_zerb;
    t_term       n_term;
    t_term       r_term;

    // unpack operands
    assign w_fa = i_a[14:10];
    assign w_fb = i_b[14:10];
    assign w_ma = (w_fa == 5'd0) ? {1'b0, i_a[9:0]} : {1'b1, i_a[9:0]};
    assign w_mb = (w_fb == 5'd0) ? {1'b0, i_b[9:0]} : {1'b1, i_b[9:0]};
    assign w_nana = (w_fa == 5'd31) && (i_a[9:0] != 10'd0);
    assign w_nanb = (w_fb == 5'd31) && (i_b[9:0] != 10'd0);
    assign w_infa = (w_fa == 5'd31) && !w_nana;
    assign w_infb = (w_fb == 5'd31) && !w_nanb;
    assign w_zera = (w_fa == 5'd0) && (i_a[9:0] == 10'd0);
    assign w_zerb = (w_fb == 5'd0) && (i_b[9:0] == 10'd0);

    // classify and multiply
    always_comb begin
        n_term.sign = i_a[15] ^ i_b[15] ^ i_neg;
        n_term.mag  = '0;
        n_term.ex   = '0;
        if (w_nana || w_nanb || (w_infa && w_zerb) || (w_infb && w_zera)) begin
            n_term.cls = CLS_NAN;
        end else if (w_infa || w_infb) begin
            n_term.cls = CLS_INF;
        end else begin
            n_term.cls = CLS_FIN;
            n_term.mag = w_ma * w_mb;
            n_term.ex  = ((w_fa == 5'd0) ? 8'sd1 : $signed({3'b000, w_fa}))
                       + ((w_fb == 5'd0) ? 8'sd1 : $signed({3'b000, w_fb}))
                       - 8'sd50;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

>>> rtl/core/rope_add.sv
// rope_add: aligns two product terms and forms the exact signed sum, registered
// depends on rope_pkg
module rope_add
    import rope_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_term i_p,
    input  t_term i_r,
    output t_sum  o_sum
);

    t_term          w_hi, w_lo;
    logic [8:0]     w_gap;
    logic [AccW-1:0] w_mh, w_ml, w_lost_mask;
    logic [5:0]     w_sh;
    logic signed [7:0] w_ex;
    t_sum           n_sum;
    t_sum           r_sum;

    // order by exponent and align
    always_comb begin
        if (i_r.ex > i_p.ex) begin
            w_hi = i_r;
            w_lo = i_p;
        end else begin
            w_hi = i_p;
            w_lo = i_r;
        end
        w_gap = 9'($signed({w_hi.ex[7], w_hi.ex}) - $signed({w_lo.ex[7], w_lo.ex}));
        w_sh  = '0;
        w_lost_mask = '0;
        if (w_gap <= 9'(AlignCap)) begin
            w_mh = AccW'(w_hi.mag) << w_gap;
            w_ml = AccW'(w_lo.mag);
            w_ex = w_lo.ex;
        end else begin
            // far term collapses to a sticky bit (gap never exceeds 63 here)
            w_sh = 6'(w_gap - 9'(AlignCap));
            w_mh = AccW'(w_hi.mag) << AlignCap;
            w_lost_mask = (AccW'(1) << w_sh) - AccW'(1);
            w_ml = (AccW'(w_lo.mag) >> w_sh)
                 | AccW'((AccW'(w_lo.mag) & w_lost_mask) != '0);
            w_ex = 8'(w_hi.ex - 8'sd40);
        end
    end

    // special cases and signed sum
    always_comb begin
        n_sum.special  = 1'b1;
        n_sum.spec_val = '0;
        n_sum.sign     = 1'b0;
        n_sum.mag      = '0;
        n_sum.ex       = w_ex;
        if (i_p.cls == CLS_NAN || i_r.cls == CLS_NAN) begin
            n_sum.spec_val = QNan;
        end else if (i_p.cls == CLS_INF && i_r.cls == CLS_INF) begin
            n_sum.spec_val = (i_p.sign != i_r.sign) ? QNan : {i_p.sign, PosInf[14:0]};
        end else if (i_p.cls == CLS_INF) begin
            n_sum.spec_val = {i_p.sign, PosInf[14:0]};
        end else if (i_r.cls == CLS_INF) begin
            n_sum.spec_val = {i_r.sign, PosInf[14:0]};
        end else if (i_p.mag == '0 && i_r.mag == '0) begin
            n_sum.spec_val = {i_p.sign & i_r.sign, 15'd0};
        end else if (i_p.mag == '0) begin
            n_sum.special = 1'b0;
            n_sum.sign = i_r.sign;
            n_sum.mag  = AccW'(i_r.mag);
            n_sum.ex   = i_r.ex;
        end else if (i_r.mag == '0) begin
            n_sum.special = 1'b0;
            n_sum.sign = i_p.sign;
            n_sum.mag  = AccW'(i_p.mag);
            n_sum.ex   = i_p.ex;
        end else if (w_hi.sign == w_lo.sign) begin
            n_sum.special = 1'b0;
            n_sum.sign = w_hi.sign;
            n_sum.mag  = w_mh + w_ml;
        end else if (w_mh == w_ml) begin
            n_sum.spec_val = 16'd0;
        end else if (w_mh > w_ml) begin
            n_sum.special = 1'b0;
            n_sum.sign = w_hi.sign;
            n_sum.mag  = w_mh - w_ml;
        end else begin
            n_sum.special = 1'b0;
            n_sum.sign = w_lo.sign;
            n_sum.mag  = w_ml - w_mh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> rtl/core/rope_round.sv
// rope_round: normalizes an exact sum and rounds it to fp16, nearest-even
// two register stages: leading-one count, then shift and round; depends on rope_pkg
module rope_round
    import rope_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en1,
    input  logic        i_en2,
    input  t_sum        i_sum,
    output logic [15:0] o_half
);

    logic [6:0]        w_len;
    t_sum              r_sum;
    logic [6:0]        r_len;
    logic signed [9:0] w_q;
    logic [6:0]        w_sh;
    logic [AccW-1:0]   w_m, w_rem, w_half, w_mask;
    logic [AccW-1:0]   w_mr;
    logic signed [9:0] w_qr;
    logic signed [9:0] w_fe;
    logic [15:0]       n_half;
    logic [15:0]       r_half;

    // bit length of the magnitude
    always_comb begin
        w_len = '0;
        for (int i = 0; i < AccW; i++) begin
            if (i_sum.mag[i]) begin
                w_len = 7'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_sum <= i_sum;
            r_len <= w_len;
        end
    end

    // shift to 11 bits and round
    always_comb begin
        w_q = 10'($signed({{2{r_sum.ex[7]}}, r_sum.ex})) + $signed({3'b000, r_len}) - 10'sd11;
        if (w_q < -10'sd24) begin
            w_q = -10'sd24;
        end
        w_sh = '0; w_mask = '0; w_rem = '0; w_half = '0; w_m = '0;
        w_qr = w_q;
        if (w_q <= $signed({{2{r_sum.ex[7]}}, r_sum.ex})) begin
            w_mr = r_sum.mag << 7'($signed({{2{r_sum.ex[7]}}, r_sum.ex}) - w_q);
        end else begin
            w_sh = 7'(w_q - $signed({{2{r_sum.ex[7]}}, r_sum.ex}));
            if (w_sh > 7'd63) begin
                w_sh = 7'd63;
            end
            w_mask = (AccW'(1) << w_sh[5:0]) - AccW'(1);
            w_rem  = r_sum.mag & w_mask;
            w_half = AccW'(1) << (w_sh[5:0] - 6'd1);
            w_m    = r_sum.mag >> w_sh[5:0];
            if (w_rem > w_half || (w_rem == w_half && w_m[0])) begin
                w_mr = w_m + AccW'(1);
            end else begin
                w_mr = w_m;
            end
            if (w_mr == AccW'(2048)) begin
                w_mr = AccW'(1024);
                w_qr = w_q + 10'sd1;
            end
        end
        w_fe = w_qr + 10'sd25;
        if (r_sum.special) begin
            n_half = r_sum.spec_val;
        end else if (r_sum.mag == '0) begin
            n_half = {r_sum.sign, 15'd0};
        end else if (w_mr < AccW'(1024)) begin
            n_half = {r_sum.sign, 5'd0, w_mr[9:0]};
        end else if (w_fe >= 10'sd31) begin
            n_half = {r_sum.sign, PosInf[14:0]};
        end else begin
            n_half = {r_sum.sign, w_fe[4:0], w_mr[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_half <= n_half;
        end
    end

    assign o_half = r_half;

endmodule

>>> rtl/core/rope_rotate_half_fp16.sv
// rope_rotate_half_fp16: rotate-half rotary embedding on one fp16 lane pair
// top level; depends on rope_pkg, rope_mul, rope_add, rope_round
//
// usage:
//   slave stream s_axis_* carries one word per lane pair:
//     tdata = {sin_val, cos_val, x_second, x_first} (x_first lowest)
//   master stream m_axis_* returns one word per input word:
//     tdata = {out_second, out_first} (out_first lowest)
//   out_first = x_first*cos - x_second*sin, out_second = x_second*cos + x_first*sin,
//   products exact, each sum rounded once to fp16 nearest-even.
// pipeline: 4 register stages (multiply, align/add, leading-one count,
//   shift/round); m_axis_tvalid rises once the word is in the shift/round
//   register, and the word leaves when m_axis_tready is high.
// throughput: one word per clock while the receiver keeps m_axis_tready high;
//   the four-stage valid pipeline holds a word every cycle.
// stall: a stage advances when it is empty or the stage after it moves, so
//   s_axis_tready drops only when every stage holds a word and the receiver
//   stalls; nothing is lost or repeated.
// reset: i_rst_n low clears all valid bits; no data registers need reset.
module rope_rotate_half_fp16
    import rope_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_first, x_second, cos_val, sin_val
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_first, out_second
);

    localparam int unsigned Stages = 4;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] w_en;
    logic [15:0] w_xf, w_xs, w_cv, w_sv;
    t_term w_p0, w_r0, w_p1, w_r1;
    t_sum  w_s0, w_s1;
    logic [15:0] w_o0, w_o1;

    // stage enables, back to front
    always_comb begin
        w_en[Stages-1] = !r_vld[Stages-1] || m_axis_tready;
        for (int i = Stages - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[Stages-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign w_xf = s_axis_tdata[15:0];
    assign w_xs = s_axis_tdata[31:16];
    assign w_cv = s_axis_tdata[47:32];
    assign w_sv = s_axis_tdata[63:48];

    // stage 1: four products
    rope_mul u_mul_fc (.i_clk, .i_en(w_en[0]), .i_a(w_xf), .i_b(w_cv), .i_neg(1'b0), .o_term(w_p0));
    rope_mul u_mul_ss (.i_clk, .i_en(w_en[0]), .i_a(w_xs), .i_b(w_sv), .i_neg(1'b1), .o_term(w_r0));
    rope_mul u_mul_sc (.i_clk, .i_en(w_en[0]), .i_a(w_xs), .i_b(w_cv), .i_neg(1'b0), .o_term(w_p1));
    rope_mul u_mul_fs (.i_clk, .i_en(w_en[0]), .i_a(w_xf), .i_b(w_sv), .i_neg(1'b0), .o_term(w_r1));

    // stage 2: aligned sums
    rope_add u_add0 (.i_clk, .i_en(w_en[1]), .i_p(w_p0), .i_r(w_r0), .o_sum(w_s0));
    rope_add u_add1 (.i_clk, .i_en(w_en[1]), .i_p(w_p1), .i_r(w_r1), .o_sum(w_s1));

    // stages 3 and 4: normalize and round
    rope_round u_rnd0 (.i_clk, .i_en1(w_en[2]), .i_en2(w_en[3]), .i_sum(w_s0), .o_half(w_o0));
    rope_round u_rnd1 (.i_clk, .i_en1(w_en[2]), .i_en2(w_en[3]), .i_sum(w_s1), .o_half(w_o1));

    assign m_axis_tdata = {w_o1, w_o0};

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // input is refused only when the whole pipe is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_vld == '1) && !m_axis_tready)
        else $error("tready low with room in pipeline");

    // an accepted word is offered on m_axis_tvalid when the output is never stalled meanwhile
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("word lost in pipeline");

endmodule

>>> test/rope_rotate_half_fp16_chk.sv
// rope_rotate_half_fp16_chk: watches both streams of the rotate-half block,
// predicts each output word from the input word and compares; needs rope_pkg
module rope_rotate_half_fp16_chk
    import rope_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_cls        cls;
        logic        sign;
        logic [63:0] mag;
        int          ex;
    } prod_t;

    logic [31:0] rotated_q[$];

    // split a half into significand and exponent
    function automatic void split_half(input logic [15:0] h, output logic [63:0] m,
                                       output int e);
        if (h[14:10] == 5'd0) begin
            m = {54'd0, h[9:0]};
            e = -24;
        end else begin
            m = {53'd0, 1'b1, h[9:0]};
            e = int'(h[14:10]) - 25;
        end
    endfunction

    // exact product of two halves, with an optional negation
    function automatic prod_t half_mul(input logic [15:0] a, input logic [15:0] b,
                                       input logic neg);
        prod_t       t;
        logic [63:0] ma, mb;
        int          ea, eb;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        split_half(a, ma, ea);
        split_half(b, mb, eb);
        nan_a = a[14:10] == 5'h1f && a[9:0] != 0;
        nan_b = b[14:10] == 5'h1f && b[9:0] != 0;
        inf_a = a[14:10] == 5'h1f && !nan_a;
        inf_b = b[14:10] == 5'h1f && !nan_b;
        zero_a = a[14:0] == 0;
        zero_b = b[14:0] == 0;
        t.sign = a[15] ^ b[15] ^ neg;
        t.mag = 0;
        t.ex = 0;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) t.cls = CLS_NAN;
        else if (inf_a || inf_b) t.cls = CLS_INF;
        else begin
            t.cls = CLS_FIN;
            t.mag = ma * mb;
            t.ex = ea + eb;
        end
        return t;
    endfunction

    // round mag * 2^ex to half, nearest-even, with gradual underflow
    function automatic logic [15:0] to_half(input logic s, input logic [63:0] mag,
                                            input int ex);
        int          len, q, sh, fe;
        logic [63:0] m, rem, halfway;
        if (mag == 0) return {s, 15'd0};
        len = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) len = i + 1;
        q = ex + len - 11;
        if (q < -24) q = -24;
        if (q <= ex) m = mag << (ex - q);
        else begin
            sh = q - ex;
            if (sh > 63) sh = 63;
            rem = mag & ((64'd1 << sh) - 1);
            halfway = 64'd1 << (sh - 1);
            m = mag >> sh;
            if (rem > halfway || (rem == halfway && m[0])) m++;
            if (m == 2048) begin
                m = 1024;
                q++;
            end
        end
        if (m < 1024) return {s, m[14:0]};
        fe = q + 25;
        if (fe >= 31) return {s, PosInf[14:0]};
        return {s, fe[4:0], m[9:0]};
    endfunction

    // a*b + (neg ? -1 : 1)*c*d, rounded once
    function automatic logic [15:0] fused_dot(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] d,
                                              input logic neg);
        prod_t       p, r, hi, lo;
        int          gap, sh, ex;
        logic [63:0] mh, ml;
        p = half_mul(a, b, 1'b0);
        r = half_mul(c, d, neg);
        if (p.cls == CLS_NAN || r.cls == CLS_NAN) return QNan;
        if (p.cls == CLS_INF && r.cls == CLS_INF)
            return (p.sign != r.sign) ? QNan : {p.sign, PosInf[14:0]};
        if (p.cls == CLS_INF) return {p.sign, PosInf[14:0]};
        if (r.cls == CLS_INF) return {r.sign, PosInf[14:0]};
        if (p.mag == 0 && r.mag == 0) return {p.sign & r.sign, 15'd0};
        if (p.mag == 0) return to_half(r.sign, r.mag, r.ex);
        if (r.mag == 0) return to_half(p.sign, p.mag, p.ex);
        hi = p;
        lo = r;
        if (r.ex > p.ex) begin
            hi = r;
            lo = p;
        end
        gap = hi.ex - lo.ex;
        if (gap <= AlignCap) begin
            mh = hi.mag << gap;
            ml = lo.mag;
            ex = lo.ex;
        end else begin
            sh = gap - AlignCap;
            mh = hi.mag << AlignCap;
            if (sh > 63) ml = 1;
            else ml = (lo.mag >> sh) | ((lo.mag & ((64'd1 << sh) - 1)) != 0);
            ex = hi.ex - AlignCap;
        end
        if (hi.sign == lo.sign) return to_half(hi.sign, mh + ml, ex);
        if (mh == ml) return 16'h0000;
        if (mh > ml) return to_half(hi.sign, mh - ml, ex);
        return to_half(lo.sign, ml - mh, ex);
    endfunction

    assign o_pending = rotated_q.size();

    // predict on input words, compare on output words
    always @(posedge i_clk) begin
        logic [15:0] xf, xs, cv, sv;
        logic [31:0] want;
        int          bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                xf = s_axis_tdata[15:0];
                xs = s_axis_tdata[31:16];
                cv = s_axis_tdata[47:32];
                sv = s_axis_tdata[63:48];
                rotated_q.push_back({fused_dot(xs, cv, xf, sv, 1'b0),
                                     fused_dot(xf, cv, xs, sv, 1'b1)});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time,
                             m_axis_tdata);
                    bad++;
                end else begin
                    want = rotated_q.pop_front();
                    if (want[15:0] != m_axis_tdata[15:0]) begin
                        $display("%0t: out_first expected %h actual %h", $time,
                                 want[15:0], m_axis_tdata[15:0]);
                        bad++;
                    end
                    if (want[31:16] != m_axis_tdata[31:16]) begin
                        $display("%0t: out_second expected %h actual %h", $time,
                                 want[31:16], m_axis_tdata[31:16]);
                        bad++;
                    end
                end
            end
            if (bad != 0) begin
                o_errors <= o_errors + bad;
            end
        end
    end
endmodule

>>> test/tb.sv
// tb: stimulus and verdict for rope_rotate_half_fp16
// depends on rope_pkg, the block and rope_rotate_half_fp16_chk
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // x_first, x_second, cos_val, sin_val
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // out_first, out_second
    int          errors, pending;
    int          send_idle = 0, recv_idle = 0;
    bit          hold_off = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rope_rotate_half_fp16 dut (.*);
    rope_rotate_half_fp16_chk chk (.*, .o_errors(errors), .o_pending(pending));

    // receiver: random stalls, or a long hold-off
    always @(posedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

    // mostly ordinary values, some specials and random patterns
    function automatic logic [15:0] pick_half();
        logic [15:0] pool[10] = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e00,
                                  16'h7bff, 16'h0001, 16'h83ff, 16'h3c00, 16'hfd55};
        case ($urandom_range(9))
            0: return pool[$urandom_range(9)];
            1, 2: return 16'($urandom);
            default: return {1'($urandom), 5'($urandom_range(24, 6)), 10'($urandom)};
        endcase
    endfunction

    // offer one word; tvalid stays high after acceptance until the next call
    task automatic send_word(input logic [63:0] w);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_word({pick_half(), pick_half(), pick_half(), pick_half()});
    endtask

    initial begin
        int spin;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes and special cases
        send_word(64'h0000_0000_0000_0000);
        send_word(64'h8000_0000_8000_0000);
        send_word(64'h8000_8000_8000_8000);
        send_word(64'hffff_ffff_ffff_ffff);
        send_word(64'h3c00_3c00_7e01_3c00);
        send_word(64'h0000_3c00_3c00_7c00);
        send_word(64'h3c00_3c00_7c00_7c00);
        send_word(64'h3c00_3c00_fc00_7c00);
        send_word(64'h3c00_0000_3c00_7c00);
        send_word(64'h3c00_7bff_7bff_7bff);
        send_word(64'h3c00_3c00_3c00_3c00);
        send_word(64'hbc00_3c00_3c00_3c00);
        send_word(64'h0001_0001_0001_0001);
        send_word(64'h03ff_3c00_0001_8001);
        send_word(64'h0001_7bff_0001_7bff);
        send_word(64'h3c00_0000_0000_3c00);
        send_word(64'h3800_3800_3c01_3c00);
        send_word(64'h0000_0000_8000_3c00);
        send_word(64'h3a00_3b00_5555_2aaa);
        send_word(64'h7c01_fe00_0000_0000);
        s_axis_tvalid <= 1'b0;
        // sender waits until every word has come back
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        send_idle = 37;
        recv_idle = 69;
        send_random(600);
        send_idle = 69;
        recv_idle = 37;
        send_random(600);
        send_idle = 0;
        recv_idle = 0;
        hold_off = 1;
        fork
            begin
                spin = 0;
                while (spin < 60) begin
                    @(posedge i_clk);
                    spin++;
                end
                hold_off = 0;
            end
            send_random(30);
        join
        send_random(620);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        spin = 0;
        while (pending != 0 && spin < 100000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("[rope_rotate_half_fp16] OK");
        else $display("[rope_rotate_half_fp16] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[rope_rotate_half_fp16] ERROR");
        $finish;
    end
endmodule
